@@ rtl/bmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bmr_pkg;

  localparam int MAX_SRC_ROWS = 256;
  localparam int MAX_SRC_COLS = 256;
  localparam int FRAC_BITS    = 16;

  // index widths of the source matrix and of one parity bank
  localparam int RW = $clog2(MAX_SRC_ROWS);
  localparam int CW = $clog2(MAX_SRC_COLS);
  localparam int RB = RW - 1;
  localparam int CB = CW - 1;
  localparam int BANK_AW    = RB + CB;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam int STEP_W = 8 + FRAC_BITS;
  localparam int PROD_W = 16 + STEP_W;
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int MUL_W  = 32 + WGT_W + 1;

  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] CFG_SRC_ROWS  = 3'd0;
  localparam logic [2:0] CFG_SRC_COLS  = 3'd1;
  localparam logic [2:0] CFG_ROW_STEP  = 3'd2;
  localparam logic [2:0] CFG_COL_STEP  = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic               op;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_row;
    logic [15:0]        out_col;
    logic signed [31:0] out_value;
  } out_item_t;

  // address stage result handed to the memory stage
  typedef struct packed {
    logic                 op;
    logic                 wr_ok;
    logic [15:0]          row;
    logic [15:0]          col;
    logic signed [31:0]   value;
    logic [RW-1:0]        i0;
    logic [RW-1:0]        i1;
    logic [CW-1:0]        j0;
    logic [CW-1:0]        j1;
    logic [FRAC_BITS-1:0] di;
    logic [FRAC_BITS-1:0] dj;
  } addr_t;

endpackage
`default_nettype wire

@@ rtl/bmr_addr.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bmr_addr (
  input  wire logic                          clk,
  input  wire logic                          en1,
  input  wire logic                          en2,
  input  wire bmr_pkg::in_item_t             item,
  input  wire logic [bmr_pkg::STEP_W-1:0]    row_step,
  input  wire logic [bmr_pkg::STEP_W-1:0]    col_step,
  input  wire logic [bmr_pkg::RW-1:0]        rows_m1,
  input  wire logic [bmr_pkg::CW-1:0]        cols_m1,
  output bmr_pkg::addr_t                     st2
);

  bmr_pkg::in_item_t            it1;
  logic [bmr_pkg::PROD_W-1:0]   ri;
  logic [bmr_pkg::PROD_W-1:0]   ci;

  logic [bmr_pkg::PROD_W-bmr_pkg::FRAC_BITS-1:0] ri_int;
  logic [bmr_pkg::PROD_W-bmr_pkg::FRAC_BITS-1:0] ci_int;
  bmr_pkg::addr_t a;

  // stage 1: coordinate products
  always_ff @(posedge clk) begin
    if (en1) begin
      it1 <= item;
      ri  <= bmr_pkg::PROD_W'(item.row) * bmr_pkg::PROD_W'(row_step);
      ci  <= bmr_pkg::PROD_W'(item.col) * bmr_pkg::PROD_W'(col_step);
    end
  end

  // stage 2: split, clamp, range check
  always_comb begin
    ri_int  = ri[bmr_pkg::PROD_W-1:bmr_pkg::FRAC_BITS];
    ci_int  = ci[bmr_pkg::PROD_W-1:bmr_pkg::FRAC_BITS];
    a.op    = it1.op;
    a.row   = it1.row;
    a.col   = it1.col;
    a.value = it1.value;
    a.wr_ok = (32'(it1.row) <= 32'(rows_m1)) && (32'(it1.col) <= 32'(cols_m1));
    a.di    = ri[bmr_pkg::FRAC_BITS-1:0];
    a.dj    = ci[bmr_pkg::FRAC_BITS-1:0];
    a.i0    = (32'(ri_int) > 32'(rows_m1)) ? rows_m1 : ri_int[bmr_pkg::RW-1:0];
    a.j0    = (32'(ci_int) > 32'(cols_m1)) ? cols_m1 : ci_int[bmr_pkg::CW-1:0];
    a.i1    = (a.i0 == rows_m1) ? a.i0 : a.i0 + 1'b1;
    a.j1    = (a.j0 == cols_m1) ? a.j0 : a.j0 + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      st2 <= a;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bmr_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bmr_bank #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bmr_interp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bmr_interp (
  input  wire logic                           clk,
  input  wire logic                           en4,
  input  wire logic                           en5,
  input  wire logic                           en6,
  input  wire logic                           en7,
  input  wire logic signed [31:0]             c00,
  input  wire logic signed [31:0]             c01,
  input  wire logic signed [31:0]             c10,
  input  wire logic signed [31:0]             c11,
  input  wire logic [bmr_pkg::FRAC_BITS-1:0]  di,
  input  wire logic [bmr_pkg::FRAC_BITS-1:0]  dj,
  input  wire logic [15:0]                    row,
  input  wire logic [15:0]                    col,
  input  wire logic [30:0]                    threshold,
  output logic                                emit,
  output bmr_pkg::out_item_t                  result
);

  localparam int MW = bmr_pkg::MUL_W;
  localparam int FB = bmr_pkg::FRAC_BITS;

  logic signed [MW-1:0] p00, p01, p10, p11;
  logic signed [MW-1:0] q0, q1;
  logic signed [31:0]   v0, v1;
  logic [FB-1:0]        di4, di5;
  logic [15:0]          row4, col4, row5, col5, row6, col6;

  logic signed [MW-1:0] s0, s1;
  logic signed [MW:0]   s;
  logic signed [MW-FB:0] sh;
  logic signed [31:0]   v;
  logic [31:0]          mag;

  // stage 4: column weights
  always_ff @(posedge clk) begin
    if (en4) begin
      p00  <= MW'(c00) * MW'($signed({1'b0, bmr_pkg::ONE - bmr_pkg::WGT_W'(dj)}));
      p01  <= MW'(c01) * MW'($signed({1'b0, bmr_pkg::WGT_W'(dj)}));
      p10  <= MW'(c10) * MW'($signed({1'b0, bmr_pkg::ONE - bmr_pkg::WGT_W'(dj)}));
      p11  <= MW'(c11) * MW'($signed({1'b0, bmr_pkg::WGT_W'(dj)}));
      di4  <= di;
      row4 <= row;
      col4 <= col;
    end
  end

  // stage 5: column sums, floor
  always_comb begin
    s0 = p00 + p01;
    s1 = p10 + p11;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      v0   <= 32'(s0 >>> FB);
      v1   <= 32'(s1 >>> FB);
      di5  <= di4;
      row5 <= row4;
      col5 <= col4;
    end
  end

  // stage 6: row weights
  always_ff @(posedge clk) begin
    if (en6) begin
      q0   <= MW'(v0) * MW'($signed({1'b0, bmr_pkg::ONE - bmr_pkg::WGT_W'(di5)}));
      q1   <= MW'(v1) * MW'($signed({1'b0, bmr_pkg::WGT_W'(di5)}));
      row6 <= row5;
      col6 <= col5;
    end
  end

  // stage 7: row sum, saturate, threshold
  always_comb begin
    s  = (MW+1)'(q0) + (MW+1)'(q1);
    sh = (MW-FB+1)'(s >>> FB);
    if (sh > (MW-FB+1)'(32'sh7fffffff)) begin
      v = 32'sh7fffffff;
    end else if (sh < -(MW-FB+1)'(33'sh080000000)) begin
      v = 32'sh80000000;
    end else begin
      v = 32'(sh);
    end
    mag  = v[31] ? (32'd0 - 32'(v)) : 32'(v);
    emit = mag > {1'b0, threshold};
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      result.out_row   <= row6;
      result.out_col   <= col6;
      result.out_value <= v;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bilinear_matrix_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// bilinear matrix resampler
// item channel (item_valid/item_ready/item): op 0 stores a signed q16.16 element
//   at (row, col), op 1 queries output position (row, col)
// result channel (result_valid/result_ready/result): one item per query whose
//   interpolated magnitude exceeds threshold; writes and small results give none
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, index 0..4
//   = src_rows, src_cols, row_step, col_step, threshold; others ignored
// throughput: one item per cycle unless clearing or a stalled receiver holds it,
//   seven register stages (product, clamp, memory read, two multiply/sum pairs
//   for column then row); a query result shows once it has passed all of them
// the store is four row/column parity banks so all corners are read in the same cycle
// reset: after rst the banks are cleared, one address per cycle in all four
//   banks at once over the 16384 addresses of each bank, with item_ready low meanwhile
// stall: each stage holds when it is full and the one after it is full and not
//   moving, so a stalled receiver backs up the pipe without loss or repeat
module bilinear_matrix_resampler (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire bmr_pkg::in_item_t   item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output bmr_pkg::out_item_t       result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  localparam int AW = bmr_pkg::BANK_AW;
  localparam int RW = bmr_pkg::RW;
  localparam int CW = bmr_pkg::CW;

  // configuration registers
  logic [8:0]                  src_rows, src_cols;
  logic [bmr_pkg::STEP_W-1:0]  row_step, col_step;
  logic [30:0]                 threshold;
  logic [RW-1:0]               rows_m1;
  logic [CW-1:0]               cols_m1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rows  <= 9'd256;
      src_cols  <= 9'd256;
      row_step  <= bmr_pkg::STEP_W'(65536);
      col_step  <= bmr_pkg::STEP_W'(65536);
      threshold <= 31'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmr_pkg::CFG_SRC_ROWS:  src_rows  <= cfg_data[8:0];
        bmr_pkg::CFG_SRC_COLS:  src_cols  <= cfg_data[8:0];
        bmr_pkg::CFG_ROW_STEP:  row_step  <= cfg_data[bmr_pkg::STEP_W-1:0];
        bmr_pkg::CFG_COL_STEP:  col_step  <= cfg_data[bmr_pkg::STEP_W-1:0];
        bmr_pkg::CFG_THRESHOLD: threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // effective size minus one, clamped to 1..max
  always_comb begin
    if (src_rows == 9'd0) begin
      rows_m1 = '0;
    end else if (32'(src_rows) > 32'(bmr_pkg::MAX_SRC_ROWS)) begin
      rows_m1 = RW'(bmr_pkg::MAX_SRC_ROWS - 1);
    end else begin
      rows_m1 = RW'(src_rows - 9'd1);
    end
    if (src_cols == 9'd0) begin
      cols_m1 = '0;
    end else if (32'(src_cols) > 32'(bmr_pkg::MAX_SRC_COLS)) begin
      cols_m1 = CW'(bmr_pkg::MAX_SRC_COLS - 1);
    end else begin
      cols_m1 = CW'(src_cols - 9'd1);
    end
  end

  // clearing pass over all banks after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(bmr_pkg::BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage occupancy and per-stage advance
  logic [7:1] v;
  logic [8:1] en;

  always_comb begin
    en[8] = result_ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign item_ready   = en[1] && !clearing;
  assign result_valid = v[7];

  bmr_pkg::addr_t st2;
  logic           emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= item_valid && item_ready;
      if (en[2]) v[2] <= v[1];
      // write items end at the memory stage
      if (en[3]) v[3] <= v[2] && (st2.op == bmr_pkg::OP_QUERY);
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4];
      if (en[6]) v[6] <= v[5];
      if (en[7]) v[7] <= v[6] && emit;
    end
  end

  bmr_addr u_addr (
    .clk      (clk),
    .en1      (en[1]),
    .en2      (en[2]),
    .item     (item),
    .row_step (row_step),
    .col_step (col_step),
    .rows_m1  (rows_m1),
    .cols_m1  (cols_m1),
    .st2      (st2)
  );

  // memory stage: bank index is {row parity, col parity}
  logic [31:0]          rdata [4];

  logic                         wr_go;
  logic [AW-1:0]                wr_addr;
  logic [1:0]                   wr_bank;
  logic [bmr_pkg::FRAC_BITS-1:0] di3, dj3;
  logic [15:0]                  row3, col3;
  logic                         pi0, pi1, pj0, pj1;

  assign wr_go   = en[3] && v[2] && (st2.op == bmr_pkg::OP_WRITE) && st2.wr_ok;
  assign wr_bank = {st2.row[0], st2.col[0]};
  assign wr_addr = {st2.row[RW-1:1], st2.col[CW-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RW-1:0] rsel;
    logic [CW-1:0] csel;
    logic          we;
    logic [AW-1:0] waddr;

    assign rsel  = (st2.i0[0] == b[1]) ? st2.i0 : st2.i1;
    assign csel  = (st2.j0[0] == b[0]) ? st2.j0 : st2.j1;
    assign we    = clearing || (wr_go && (wr_bank == 2'(b)));
    assign waddr = clearing ? clr_addr : wr_addr;

    bmr_bank #(.AW(AW), .DW(32)) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (clearing ? 32'd0 : 32'(st2.value)),
      .re    (en[3]),
      .raddr ({rsel[RW-1:1], csel[CW-1:1]}),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      di3  <= st2.di;
      dj3  <= st2.dj;
      row3 <= st2.row;
      col3 <= st2.col;
      pi0  <= st2.i0[0];
      pi1  <= st2.i1[0];
      pj0  <= st2.j0[0];
      pj1  <= st2.j1[0];
    end
  end

  bmr_interp u_interp (
    .clk       (clk),
    .en4       (en[4]),
    .en5       (en[5]),
    .en6       (en[6]),
    .en7       (en[7]),
    .c00       ($signed(rdata[{pi0, pj0}])),
    .c01       ($signed(rdata[{pi0, pj1}])),
    .c10       ($signed(rdata[{pi1, pj0}])),
    .c11       ($signed(rdata[{pi1, pj1}])),
    .di        (di3),
    .dj        (dj3),
    .row       (row3),
    .col       (col3),
    .threshold (threshold),
    .emit      (emit),
    .result    (result)
  );

endmodule
`default_nettype wire

@@ rtl/bmr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bmr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire bmr_pkg::out_item_t result
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // clearing pass keeps the item side closed right after reset
  a_clear: assert property (@(posedge clk) rst |=> !item_ready && !result_valid)
    else $error("item taken or result shown during clearing");

  // threshold is never negative, so an emitted value is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.out_value != 32'sd0)
    else $error("zero result emitted");

endmodule

bind bilinear_matrix_resampler bmr_checker u_bmr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire

@@ tb/tb_bilinear_matrix_resampler.sv @@
`timescale 1ns / 1ps
module tb_bilinear_matrix_resampler;

  // resampler scoreboard: own copy of the source store and registers
  class resample_scoreboard;
    logic [31:0] store [0:bmr_pkg::MAX_SRC_ROWS*bmr_pkg::MAX_SRC_COLS-1];
    logic [8:0]  rows_reg, cols_reg;
    logic [23:0] rstep, cstep;
    logic [30:0] thresh;
    bmr_pkg::out_item_t pending [$];
    int          errors;

    function new();
      foreach (store[i]) store[i] = '0;
      rows_reg = 256; cols_reg = 256;
      rstep = 65536; cstep = 65536;
      thresh = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        bmr_pkg::CFG_SRC_ROWS:  rows_reg = d[8:0];
        bmr_pkg::CFG_SRC_COLS:  cols_reg = d[8:0];
        bmr_pkg::CFG_ROW_STEP:  rstep = d[23:0];
        bmr_pkg::CFG_COL_STEP:  cstep = d[23:0];
        bmr_pkg::CFG_THRESHOLD: thresh = d[30:0];
        default: ;
      endcase
    endfunction

    function longint blend(longint a, longint b, longint w);
      // arithmetic shift floors toward minus infinity
      return (a * ((longint'(1) << bmr_pkg::FRAC_BITS) - w) + b * w) >>> bmr_pkg::FRAC_BITS;
    endfunction

    function longint elem(longint r, longint c);
      return longint'($signed(store[r * bmr_pkg::MAX_SRC_COLS + c]));
    endfunction

    // note an accepted input item
    function void note_item(bmr_pkg::in_item_t it);
      longint rows, cols, ri, ci, i0, j0, i1, j1, di, dj, v0, v1, v, mag;
      bmr_pkg::out_item_t o;
      rows = (rows_reg == 0) ? 1 :
             (rows_reg > bmr_pkg::MAX_SRC_ROWS ? bmr_pkg::MAX_SRC_ROWS : rows_reg);
      cols = (cols_reg == 0) ? 1 :
             (cols_reg > bmr_pkg::MAX_SRC_COLS ? bmr_pkg::MAX_SRC_COLS : cols_reg);
      if (it.op == bmr_pkg::OP_WRITE) begin
        if (it.row < rows && it.col < cols)
          store[it.row * bmr_pkg::MAX_SRC_COLS + it.col] = it.value;
        return;
      end
      ri = longint'(it.row) * longint'(rstep);
      ci = longint'(it.col) * longint'(cstep);
      i0 = ri >> bmr_pkg::FRAC_BITS; j0 = ci >> bmr_pkg::FRAC_BITS;
      di = ri & ((1 << bmr_pkg::FRAC_BITS) - 1);
      dj = ci & ((1 << bmr_pkg::FRAC_BITS) - 1);
      if (i0 > rows - 1) i0 = rows - 1;
      if (j0 > cols - 1) j0 = cols - 1;
      i1 = (i0 + 1 > rows - 1) ? rows - 1 : i0 + 1;
      j1 = (j0 + 1 > cols - 1) ? cols - 1 : j0 + 1;
      v0 = blend(elem(i0, j0), elem(i0, j1), dj);
      v1 = blend(elem(i1, j0), elem(i1, j1), dj);
      v = blend(v0, v1, di);
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      mag = (v < 0) ? -v : v;
      if (mag <= longint'(thresh)) return;
      o.out_row = it.row; o.out_col = it.col; o.out_value = v[31:0];
      pending.push_back(o);
    endfunction

    // compare a result against the oldest expectation
    function void check_result(bmr_pkg::out_item_t got);
      bmr_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result row %0d col %0d value %0d",
               got.out_row, got.out_col, got.out_value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_row !== e.out_row) begin
        $error("out_row expected %0d actual %0d", e.out_row, got.out_row); errors++;
      end
      if (got.out_col !== e.out_col) begin
        $error("out_col expected %0d actual %0d", e.out_col, got.out_col); errors++;
      end
      if (got.out_value !== e.out_value) begin
        $error("out_value expected %0d actual %0d", e.out_value, got.out_value); errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        item_valid = 0, item_ready;
  bmr_pkg::in_item_t  item = '0;
  logic        result_valid, result_ready = 0;
  bmr_pkg::out_item_t result;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  resample_scoreboard sb;
  bit          calm = 0;    // last part of the run: no idling on either side
  int          dense_pct = 0;

  bilinear_matrix_resampler u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver: random stall bursts, checks on every accepted result
  initial begin
    int stall;
    sb = new();
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result);
      if (stall > 0) begin
        stall--;
        result_ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        result_ready <= 0;
      end else result_ready <= 1;
    end
  end

  // drive one item and wait until it is accepted, with an optional gap first;
  // valid stays up after acceptance so the next item can follow directly
  task automatic send_item(bmr_pkg::in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 8);
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  // write a register only while the pipe is drained
  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    // queries under threshold give nothing, so let the pipe empty out
    repeat (12) @(posedge clk);
  endtask

  task automatic put(bit op, int r, int c, logic [31:0] v);
    bmr_pkg::in_item_t it;
    it.op = op; it.row = 16'(r); it.col = 16'(c); it.value = v;
    send_item(it);
  endtask

  // random item biased toward the configured matrix size
  task automatic rand_item();
    bmr_pkg::in_item_t it;
    int lim_r, lim_c;
    lim_r = (sb.rows_reg == 0) ? 1 : (sb.rows_reg > 256 ? 256 : sb.rows_reg);
    lim_c = (sb.cols_reg == 0) ? 1 : (sb.cols_reg > 256 ? 256 : sb.cols_reg);
    it.op = ($urandom_range(0, 99) < dense_pct) ? bmr_pkg::OP_WRITE : bmr_pkg::OP_QUERY;
    case ($urandom_range(0, 9))
      0: begin it.row = 16'($urandom); it.col = 16'($urandom); end
      1: begin
        it.row = 16'($urandom_range(0, 300));
        it.col = 16'($urandom_range(0, 300));
      end
      default: begin
        it.row = 16'($urandom_range(0, lim_r + 1));
        it.col = 16'($urandom_range(0, lim_c + 1));
      end
    endcase
    case ($urandom_range(0, 5))
      0: it.value = 32'h7FFFFFFF;
      1: it.value = 32'h80000000;
      default: it.value = $urandom;
    endcase
    send_item(it);
  endtask

  task automatic phase(logic [8:0] r, logic [8:0] c, logic [23:0] rs, logic [23:0] cs,
                       logic [30:0] th, int n);
    drain();
    write_cfg(bmr_pkg::CFG_SRC_ROWS, 32'(r));
    write_cfg(bmr_pkg::CFG_SRC_COLS, 32'(c));
    write_cfg(bmr_pkg::CFG_ROW_STEP, 32'(rs));
    write_cfg(bmr_pkg::CFG_COL_STEP, 32'(cs));
    write_cfg(bmr_pkg::CFG_THRESHOLD, 32'(th));
    repeat (n) rand_item();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extremes, both operations, corner clamping, emptiness
    put(bmr_pkg::OP_QUERY, 0, 0, 0);                  // untouched store reads zero
    put(bmr_pkg::OP_WRITE, 0, 0, 32'h7FFFFFFF);
    put(bmr_pkg::OP_WRITE, 0, 1, 32'h80000000);
    put(bmr_pkg::OP_WRITE, 1, 0, 32'h00010000);
    put(bmr_pkg::OP_WRITE, 1, 1, 32'hFFFF0000);
    put(bmr_pkg::OP_WRITE, 255, 255, 32'h12345678);
    put(bmr_pkg::OP_WRITE, 256, 0, 32'h1);            // outside size, ignored
    put(bmr_pkg::OP_WRITE, 65535, 65535, 32'hFFFFFFFF);
    put(bmr_pkg::OP_QUERY, 0, 0, 0);
    put(bmr_pkg::OP_QUERY, 255, 255, 0);              // far neighbors clamp to the edge
    put(bmr_pkg::OP_QUERY, 65535, 65535, 32'hFFFFFFFF); // mapped past the last row
    drain();
    write_cfg(bmr_pkg::CFG_ROW_STEP, 32'h008000);     // half steps: fractional blending
    write_cfg(bmr_pkg::CFG_COL_STEP, 32'h008000);
    write_cfg(3'd7, 32'hFFFFFFFF);                    // index beyond the list
    put(bmr_pkg::OP_QUERY, 1, 1, 0);
    put(bmr_pkg::OP_QUERY, 1, 0, 0);
    put(bmr_pkg::OP_QUERY, 0, 1, 0);
    drain();
    write_cfg(bmr_pkg::CFG_SRC_ROWS, 32'd0);          // zero size clamps to one
    write_cfg(bmr_pkg::CFG_SRC_COLS, 32'h1FF);        // oversize clamps to max
    write_cfg(bmr_pkg::CFG_THRESHOLD, 32'h7FFFFFFF);
    put(bmr_pkg::OP_WRITE, 1, 0, 32'h5);
    put(bmr_pkg::OP_QUERY, 3, 3, 0);
    drain();
    write_cfg(bmr_pkg::CFG_SRC_ROWS, 32'd256);        // left over elements come back
    write_cfg(bmr_pkg::CFG_THRESHOLD, 32'd0);
    put(bmr_pkg::OP_QUERY, 1, 0, 0);

    // random phases, mostly small matrices so queries hit written data
    dense_pct = 50;
    phase(4, 4, 24'h00C000, 24'h005555, 0, 200);
    phase(2, 3, 24'hFFFFFF, 24'h000000, 31'h00008000, 150);
    phase(8, 8, 24'h010000, 24'h012345, 0, 250);
    phase(1, 1, 24'h000001, 24'h000001, 0, 100);
    phase(256, 256, 24'($urandom), 24'($urandom), 31'h00010000, 250);
    phase(16, 5, 24'($urandom_range(0, 24'h4FFFF)), 24'($urandom_range(0, 24'h4FFFF)),
          0, 250);
    phase(9'h1FF, 0, 24'($urandom_range(0, 24'h3FFFF)), 24'($urandom_range(0, 24'h3FFFF)),
          31'h7FFFFFFF, 150);
    dense_pct = 40;
    phase(6, 7, 24'($urandom_range(0, 24'h2FFFF)), 24'($urandom_range(0, 24'h2FFFF)),
          31'($urandom_range(0, 31'h0FFFFF)), 200);
    drain();
    calm = 1;
    phase(3, 3, 24'h00A000, 24'h006000, 0, 250);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_bilinear_matrix_resampler passed");
    else
      $display("tb_bilinear_matrix_resampler failed");
    $finish;
  end

  // hard limit: store clear plus a worst case stalled run
  initial begin
    #20ms;
    $display("tb_bilinear_matrix_resampler failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bmr_pkg.sv
rtl/bmr_addr.sv
rtl/bmr_bank.sv
rtl/bmr_interp.sv
rtl/bilinear_matrix_resampler.sv
rtl/bmr_checker.sv
tb/tb_bilinear_matrix_resampler.sv
